// ===== hdl/ura_pkg.sv =====
// Package: constants, codes and shared types for the ultrasonic ranger with averaging.
`default_nettype none
package ura_pkg;

  localparam int MAX_SAMPLES_DEF = 64;

  localparam int CFG_W   = 11;
  localparam int IDX_W   = 3;
  localparam int CM_W    = 11;
  localparam int WIDTH_W = 17;
  localparam int MS_W    = 8;
  localparam int TRIG_W  = 6;
  localparam int DIV_W   = 26;
  localparam int DEN_W   = 15;

  // 20000 = 32 * 625: drop 5 bits, multiply by ceil(2^31 / 625), drop 31 bits
  localparam int PROD_SHIFT  = 5;
  localparam int RECIP_W     = 22;
  localparam int SOUND_SHIFT = 31;
  localparam int SCALE_W     = 12;

  localparam logic [CM_W-1:0]    CM_MAX      = 11'd2047;
  localparam logic [WIDTH_W-1:0] WIDTH_MAX   = 17'd131071;
  localparam logic [MS_W-1:0]    MS_MAX      = 8'd255;
  localparam logic [DIV_W-1:0]   SOUND_MUL   = 26'd343;
  localparam logic [RECIP_W-1:0] SOUND_RECIP = 22'd3435974;

  localparam logic [6:0]      SAMPLE_COUNT_RST = 7'd10;
  localparam logic [6:0]      TIMEOUT_RST      = 7'd40;
  localparam logic [7:0]      COOLDOWN_RST     = 8'd60;
  localparam logic [CM_W-1:0] FAR_RST          = 11'd400;
  localparam logic [5:0]      TRIGGER_RST      = 6'd15;
  localparam logic [CM_W-1:0] AVERAGE_RST      = 11'd400;

  typedef enum logic [IDX_W-1:0] {
    REG_SAMPLE_COUNT = 3'd0,
    REG_TIMEOUT      = 3'd1,
    REG_COOLDOWN     = 3'd2,
    REG_FAR          = 3'd3,
    REG_TRIGGER      = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    PH_TRIGGER = 2'd0,
    PH_WAIT    = 2'd1,
    PH_COOL    = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,
    ST_MUL,
    ST_DIV,
    ST_COMMIT
  } ctrl_state_t;

  typedef struct packed {
    logic load_in;
    logic mul_load;
    logic scale_load;
    logic div_start;
    logic commit;
  } ura_cmd_t;

  typedef struct packed {
    logic fall_hit;
    logic avg_hit;
    logic div_done;
  } ura_status_t;

endpackage
`default_nettype wire

// ===== hdl/ura_divider.sv =====
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module ura_divider
  import ura_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DIV_W-1:0] dividend,
  input  wire logic [DEN_W-1:0] divisor,
  output logic                  done,
  output logic [DIV_W-1:0]      quotient
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den;
  logic [DEN_W:0]   rem_sh;
  logic             fits;

  assign rem_sh = {rem, quotient[DIV_W-1]};
  assign fits   = rem_sh >= {1'b0, den};
  assign done   = !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(DIV_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      den      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= fits ? DEN_W'(rem_sh - {1'b0, den}) : rem_sh[DEN_W-1:0];
      quotient <= {quotient[DIV_W-2:0], fits};
    end
  end

endmodule
`default_nettype wire

// ===== hdl/ura_ctrl.sv =====
// Controller: sequences each input beat through evaluation, multiply and scale or division, and commit.
`default_nettype none
module ura_ctrl
  import ura_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  wire logic        out_stall,
  input  wire ura_status_t status,
  output ura_cmd_t         cmd
);

  ctrl_state_t state, state_next;
  logic        out_free;
  logic        out_valid_next;

  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_STEP;
        end
      end
      ST_STEP: begin
        priority if (status.fall_hit) begin
          state_next = ST_MUL;
        end else if (status.avg_hit) begin
          state_next = ST_DIV;
        end else if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_MUL: begin
        state_next = ST_COMMIT;
      end
      ST_DIV: begin
        if (status.div_done) begin
          state_next = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = (state != ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        cmd.load_in = in_valid;
      end
      ST_STEP: begin
        priority if (status.fall_hit) begin
          cmd.mul_load = 1'b1;
        end else if (status.avg_hit) begin
          cmd.div_start = 1'b1;
        end else begin
          cmd.commit = out_free;
        end
      end
      ST_MUL: begin
        cmd.scale_load = 1'b1;
      end
      ST_DIV: begin
        cmd.commit = 1'b0;
      end
      ST_COMMIT: begin
        cmd.commit = out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  assign out_valid_next = cmd.commit ? 1'b1 : (out_valid && out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/ura_datapath.sv =====
// Datapath: configuration, ranging state, echo timing, sample sum and output register.
`default_nettype none
module ura_datapath
  import ura_pkg::*;
#(
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_write,
  input  wire logic [IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data,
  input  wire logic             echo_level,
  input  wire logic             ms_tick,
  input  wire ura_cmd_t         cmd,
  output ura_status_t           status,
  output logic                  trigger_level,
  output logic                  result_valid,
  output logic [CM_W-1:0]       distance_cm
);

  localparam int SUM_W = $clog2(MAX_SAMPLES * 2047 + 1);
  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int TGT_W = (CNT_W > 7) ? CNT_W : 7;
  localparam int SPROD_W = DIV_W - PROD_SHIFT + RECIP_W;
  localparam logic [TGT_W-1:0] TGT_MAX = TGT_W'(MAX_SAMPLES);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SAMPLES);

  // configuration
  logic [6:0]      sample_count;
  logic [6:0]      echo_timeout_ms;
  logic [7:0]      cooldown_ms;
  logic [CM_W-1:0] far_distance_cm;
  logic [5:0]      trigger_us;

  // ranging state
  phase_t             phase, phase_next;
  logic [TRIG_W-1:0]  trigger_timer, trigger_timer_next;
  logic [MS_W-1:0]    phase_ms_count, phase_ms_count_next;
  logic               echo_high_seen, echo_high_seen_next;
  logic [WIDTH_W-1:0] echo_width_us, echo_width_us_next;
  logic [SUM_W-1:0]   sample_sum, sample_sum_next;
  logic [CNT_W-1:0]   samples_taken, samples_taken_next;
  logic [CM_W-1:0]    average_cm, average_cm_next;
  logic               echo_prev;

  logic               echo_in;
  logic               tick_in;
  logic [DIV_W-1:0]   product;
  logic [SPROD_W-1:0] scale_prod;
  logic [SCALE_W-1:0] scaled;
  logic               trig_next;
  logic               valid_next;

  logic               rising, falling;
  logic [MS_W-1:0]    ms_inc;
  logic [WIDTH_W-1:0] width_inc;
  logic [TRIG_W-1:0]  tt_inc;
  logic [TRIG_W-1:0]  width_target;
  logic [TGT_W-1:0]   target;
  logic               cool_end;
  logic               enough;
  logic [CM_W-1:0]    q_cm;
  logic               rec;
  logic [CM_W-1:0]    rec_cm;

  logic               div_done;
  logic [DIV_W-1:0]   quotient;
  logic [DIV_W-1:0]   div_dividend;
  logic [DEN_W-1:0]   div_divisor;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count    <= SAMPLE_COUNT_RST;
      echo_timeout_ms <= TIMEOUT_RST;
      cooldown_ms     <= COOLDOWN_RST;
      far_distance_cm <= FAR_RST;
      trigger_us      <= TRIGGER_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SAMPLE_COUNT: sample_count    <= cfg_data[6:0];
        REG_TIMEOUT:      echo_timeout_ms <= cfg_data[6:0];
        REG_COOLDOWN:     cooldown_ms     <= cfg_data[7:0];
        REG_FAR:          far_distance_cm <= cfg_data;
        REG_TRIGGER:      trigger_us      <= cfg_data[5:0];
        default: begin
        end
      endcase
    end
  end

  assign scale_prod = product[DIV_W-1:PROD_SHIFT] * SOUND_RECIP;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      echo_in <= echo_level;
      tick_in <= ms_tick;
    end
    if (cmd.mul_load) begin
      product <= DIV_W'(width_inc) * SOUND_MUL;
    end
    if (cmd.scale_load) begin
      scaled <= scale_prod[SOUND_SHIFT +: SCALE_W];
    end
  end

  assign rising    = echo_in && !echo_prev;
  assign falling   = !echo_in && echo_prev;
  assign ms_inc    = (tick_in && phase_ms_count != MS_MAX) ? phase_ms_count + 1'b1
                                                           : phase_ms_count;
  assign width_inc = (echo_high_seen && echo_width_us != WIDTH_MAX) ? echo_width_us + 1'b1
                                                                    : echo_width_us;
  assign tt_inc       = trigger_timer + 1'b1;
  assign width_target = (trigger_us == '0) ? TRIG_W'(1) : trigger_us;

  always_comb begin
    if (sample_count == '0) begin
      target = TGT_W'(1);
    end else if (TGT_W'(sample_count) > TGT_MAX) begin
      target = TGT_MAX;
    end else begin
      target = TGT_W'(sample_count);
    end
  end

  assign cool_end = ms_inc >= cooldown_ms;
  assign enough   = (TGT_W'(samples_taken) >= target) && (samples_taken != '0);

  assign status.fall_hit = (phase == PH_WAIT) && echo_high_seen && falling;
  assign status.avg_hit  = (phase == PH_COOL) && cool_end && enough;
  assign status.div_done = div_done;

  assign div_dividend = DIV_W'(sample_sum);
  assign div_divisor  = DEN_W'(samples_taken);

  ura_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  assign q_cm = (scaled > SCALE_W'(CM_MAX)) ? CM_MAX : scaled[CM_W-1:0];

  always_comb begin
    phase_next          = phase;
    trigger_timer_next  = trigger_timer;
    phase_ms_count_next = phase_ms_count;
    echo_high_seen_next = echo_high_seen;
    echo_width_us_next  = echo_width_us;
    sample_sum_next     = sample_sum;
    samples_taken_next  = samples_taken;
    average_cm_next     = average_cm;
    trig_next           = 1'b0;
    valid_next          = 1'b0;
    rec                 = 1'b0;
    rec_cm              = far_distance_cm;
    unique case (phase)
      PH_TRIGGER: begin
        trig_next = 1'b1;
        if (tt_inc >= width_target || tt_inc == '0) begin
          trigger_timer_next  = '0;
          phase_next          = PH_WAIT;
          phase_ms_count_next = '0;
          echo_high_seen_next = 1'b0;
          echo_width_us_next  = '0;
        end else begin
          trigger_timer_next = tt_inc;
        end
      end
      PH_WAIT: begin
        phase_ms_count_next = ms_inc;
        echo_width_us_next  = width_inc;
        if (echo_high_seen && falling) begin
          echo_high_seen_next = 1'b0;
          rec                 = 1'b1;
          rec_cm              = q_cm;
        end else begin
          if (!echo_high_seen && rising) begin
            echo_high_seen_next = 1'b1;
            echo_width_us_next  = '0;
          end
          if (ms_inc >= MS_W'(echo_timeout_ms)) begin
            echo_high_seen_next = 1'b0;
            rec                 = 1'b1;
          end
        end
        if (rec) begin
          sample_sum_next     = sample_sum + SUM_W'(rec_cm);
          samples_taken_next  = (samples_taken < CNT_MAX) ? samples_taken + 1'b1
                                                          : samples_taken;
          phase_next          = PH_COOL;
          phase_ms_count_next = '0;
        end
      end
      PH_COOL: begin
        phase_ms_count_next = ms_inc;
        if (cool_end) begin
          if (enough) begin
            average_cm_next    = quotient[CM_W-1:0];
            sample_sum_next    = '0;
            samples_taken_next = '0;
            valid_next         = 1'b1;
          end
          phase_next          = PH_TRIGGER;
          trigger_timer_next  = '0;
          phase_ms_count_next = '0;
        end
      end
      default: begin
        phase_next          = PH_TRIGGER;
        trigger_timer_next  = '0;
        phase_ms_count_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_TRIGGER;
      trigger_timer  <= '0;
      phase_ms_count <= '0;
      echo_high_seen <= 1'b0;
      echo_width_us  <= '0;
      sample_sum     <= '0;
      samples_taken  <= '0;
      average_cm     <= AVERAGE_RST;
      echo_prev      <= 1'b0;
    end else if (cmd.commit) begin
      phase          <= phase_next;
      trigger_timer  <= trigger_timer_next;
      phase_ms_count <= phase_ms_count_next;
      echo_high_seen <= echo_high_seen_next;
      echo_width_us  <= echo_width_us_next;
      sample_sum     <= sample_sum_next;
      samples_taken  <= samples_taken_next;
      average_cm     <= average_cm_next;
      echo_prev      <= echo_in;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      trigger_level <= trig_next;
      result_valid  <= valid_next;
      distance_cm   <= average_cm_next;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/ultrasonic_ranger_averaging.sv =====
// Top level: ultrasonic ranger with averaging, controller plus datapath.
// Sequence: a plain beat is accepted in IDLE and gives its result beat from STEP; an echo end
// takes STEP (multiply), MUL (reciprocal scale) and COMMIT; a completed average takes STEP
// (divider start), DIV until the divider is done, and COMMIT. One beat is in flight at a time.
// A stalled result beat holds the controller and so holds off the next input beat.
// Reset (synchronous, active high) restores register defaults, TRIGGER phase, average 400.
`default_nettype none
module ultrasonic_ranger_averaging
  import ura_pkg::*;
#(
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_write,
  input  wire logic [IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic             echo_level,
  input  wire logic             ms_tick,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic                  trigger_level,
  output logic                  result_valid,
  output logic [CM_W-1:0]       distance_cm
);

  ura_cmd_t    cmd;
  ura_status_t status;

  ura_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  ura_datapath #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .echo_level    (echo_level),
    .ms_tick       (ms_tick),
    .cmd           (cmd),
    .status        (status),
    .trigger_level (trigger_level),
    .result_valid  (result_valid),
    .distance_cm   (distance_cm)
  );

endmodule
`default_nettype wire

// ===== verif/ultrasonic_ranger_averaging_test.sv =====
// Self-checking testbench for the ultrasonic ranger with averaging.
`timescale 1ns / 1ps
module ultrasonic_ranger_averaging_test;
  import ura_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int TAIL_CYCLES = 40;
  localparam int REPORT_MAX  = 10;
  localparam int NUM_ROWS    = 20;
  localparam int NUM_PHASES  = 8;

  typedef struct packed {
    logic            trig;
    logic            valid;
    logic [CM_W-1:0] cm;
  } ranger_beat_t;

  typedef enum logic {
    ROW_BEAT,
    ROW_REG
  } row_kind_t;

  typedef struct packed {
    row_kind_t       kind;
    reg_idx_t        index;
    logic [CFG_W-1:0] data;
    logic            echo;
    logic            tick;
    logic [17:0]     reps;
    logic            typed;
    ranger_beat_t    want;
  } plan_row_t;

  localparam plan_row_t DIRECTED_PLAN [NUM_ROWS] = '{
    '{ROW_BEAT, REG_SAMPLE_COUNT, 11'd0,    1'b0, 1'b0, 18'd1,      1'b1, '{1'b1, 1'b0, 11'd400}},
    '{ROW_REG,  REG_TRIGGER,      11'd0,    1'b0, 1'b0, 18'd0,      1'b0, '0},
    '{ROW_REG,  REG_SAMPLE_COUNT, 11'd0,    1'b0, 1'b0, 18'd0,      1'b0, '0},
    '{ROW_REG,  REG_TIMEOUT,      11'd2,    1'b0, 1'b0, 18'd0,      1'b0, '0},
    '{ROW_REG,  REG_COOLDOWN,     11'd1,    1'b0, 1'b0, 18'd0,      1'b0, '0},
    '{ROW_REG,  REG_FAR,          11'd2047, 1'b0, 1'b0, 18'd0,      1'b0, '0},
    '{ROW_BEAT, REG_SAMPLE_COUNT, 11'd0,    1'b1, 1'b0, 18'd1,      1'b1, '{1'b1, 1'b0, 11'd400}},
    '{ROW_BEAT, REG_SAMPLE_COUNT, 11'd0,    1'b1, 1'b0, 18'd3,      1'b0, '0},
    '{ROW_BEAT, REG_SAMPLE_COUNT, 11'd0,    1'b0, 1'b1, 18'd1,      1'b0, '0},
    '{ROW_BEAT, REG_SAMPLE_COUNT, 11'd0,    1'b0, 1'b1, 18'd1,      1'b0, '0},
    '{ROW_BEAT, REG_SAMPLE_COUNT, 11'd0,    1'b0, 1'b1, 18'd1,      1'b1, '{1'b0, 1'b1, 11'd2047}},
    '{ROW_BEAT, REG_SAMPLE_COUNT, 11'd0,    1'b0, 1'b0, 18'd1,      1'b1, '{1'b1, 1'b0, 11'd2047}},
    '{ROW_BEAT, REG_SAMPLE_COUNT, 11'd0,    1'b1, 1'b0, 18'd1,      1'b0, '0},
    '{ROW_BEAT, REG_SAMPLE_COUNT, 11'd0,    1'b1, 1'b1, 18'd1,      1'b0, '0},
    '{ROW_BEAT, REG_SAMPLE_COUNT, 11'd0,    1'b0, 1'b1, 18'd1,      1'b0, '0},
    '{ROW_BEAT, REG_SAMPLE_COUNT, 11'd0,    1'b0, 1'b1, 18'd1,      1'b1, '{1'b0, 1'b1, 11'd0}},
    '{ROW_BEAT, REG_SAMPLE_COUNT, 11'd0,    1'b0, 1'b0, 18'd1,      1'b0, '0},
    '{ROW_BEAT, REG_SAMPLE_COUNT, 11'd0,    1'b1, 1'b0, 18'd60,     1'b0, '0},
    '{ROW_BEAT, REG_SAMPLE_COUNT, 11'd0,    1'b0, 1'b0, 18'd1,      1'b0, '0},
    '{ROW_BEAT, REG_SAMPLE_COUNT, 11'd0,    1'b0, 1'b1, 18'd1,      1'b0, '0}
  };

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_write = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic             echo_level = 1'b0;
  logic             ms_tick = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic             trigger_level;
  logic             result_valid;
  logic [CM_W-1:0]  distance_cm;

  ultrasonic_ranger_averaging i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .echo_level   (echo_level),
    .ms_tick      (ms_tick),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .trigger_level(trigger_level),
    .result_valid (result_valid),
    .distance_cm  (distance_cm)
  );

  // Mirror of the ranger registers and state
  logic [6:0]        samples_reg;
  logic [6:0]        timeout_reg;
  logic [7:0]        cooldown_reg;
  logic [CM_W-1:0]   far_reg;
  logic [TRIG_W-1:0] trigger_reg;
  phase_t            ranger_phase;
  logic [TRIG_W-1:0] pulse_timer;
  logic [MS_W-1:0]   ms_count;
  logic              echo_seen;
  logic [WIDTH_W-1:0] width_us;
  logic [16:0]       sum_cm;
  logic [6:0]        taken;
  logic [CM_W-1:0]   avg_cm;
  logic              echo_last;

  ranger_beat_t ranger_outputs_due [$];
  int mismatches = 0;
  int quiet_cycles = 0;
  int idle_pct = 0;
  int stall_pct = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void reset_ranger();
    samples_reg  = 7'd10;
    timeout_reg  = 7'd40;
    cooldown_reg = 8'd60;
    far_reg      = 11'd400;
    trigger_reg  = 6'd15;
    ranger_phase = PH_TRIGGER;
    pulse_timer  = '0;
    ms_count     = '0;
    echo_seen    = 1'b0;
    width_us     = '0;
    sum_cm       = '0;
    taken        = '0;
    avg_cm       = 11'd400;
    echo_last    = 1'b0;
  endfunction

  function automatic void record_sample(input logic [31:0] cm_raw);
    sum_cm = sum_cm + ((cm_raw > CM_MAX) ? CM_MAX : cm_raw[CM_W-1:0]);
    if (taken < MAX_SAMPLES_DEF) taken = taken + 7'd1;
    ranger_phase = PH_COOL;
    ms_count = '0;
  endfunction

  function automatic ranger_beat_t advance_ranger(input logic echo, input logic tick);
    logic              rising;
    logic              falling;
    logic [TRIG_W-1:0] pulse_target;
    logic [6:0]        needed;
    ranger_beat_t      beat;
    rising  = echo & ~echo_last;
    falling = ~echo & echo_last;
    beat.trig  = 1'b0;
    beat.valid = 1'b0;
    case (ranger_phase)
      PH_TRIGGER: begin
        beat.trig = 1'b1;
        pulse_target = (trigger_reg == 0) ? 6'd1 : trigger_reg;
        pulse_timer = pulse_timer + 6'd1;
        if (pulse_timer >= pulse_target || pulse_timer == 0) begin
          pulse_timer  = '0;
          ranger_phase = PH_WAIT;
          ms_count     = '0;
          echo_seen    = 1'b0;
          width_us     = '0;
        end
      end
      PH_WAIT: begin
        if (tick && ms_count != MS_MAX) ms_count = ms_count + 8'd1;
        if (echo_seen && width_us != WIDTH_MAX) width_us = width_us + 17'd1;
        if (echo_seen && falling) begin
          echo_seen = 1'b0;
          record_sample((32'(width_us) * 32'd343) / 32'd20000);
        end else begin
          if (!echo_seen && rising) begin
            echo_seen = 1'b1;
            width_us  = '0;
          end
          if (ms_count >= {1'b0, timeout_reg}) begin
            echo_seen = 1'b0;
            record_sample(32'(far_reg));
          end
        end
      end
      PH_COOL: begin
        if (tick && ms_count != MS_MAX) ms_count = ms_count + 8'd1;
        if (ms_count >= cooldown_reg) begin
          needed = (samples_reg == 0) ? 7'd1 : samples_reg;
          if (needed > MAX_SAMPLES_DEF) needed = 7'(MAX_SAMPLES_DEF);
          if (taken >= needed && taken != 0) begin
            avg_cm = 11'((sum_cm / 17'(taken)) & 17'(CM_MAX));
            sum_cm = '0;
            taken  = '0;
            beat.valid = 1'b1;
          end
          ranger_phase = PH_TRIGGER;
          pulse_timer  = '0;
          ms_count     = '0;
        end
      end
      default: begin
        ranger_phase = PH_TRIGGER;
        pulse_timer  = '0;
        ms_count     = '0;
      end
    endcase
    echo_last = echo;
    beat.cm = avg_cm;
    return beat;
  endfunction

  task automatic send_beat(input logic echo, input logic tick, input logic typed,
                           input ranger_beat_t typed_beat);
    ranger_beat_t predicted;
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid   <= 1'b1;
    echo_level <= echo;
    ms_tick    <= tick;
    do @(posedge clk); while (in_stall);
    predicted = advance_ranger(echo, tick);
    ranger_outputs_due.push_back(typed ? typed_beat : predicted);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (ranger_outputs_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t index, input logic [CFG_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    case (index)
      REG_SAMPLE_COUNT: samples_reg  = data[6:0];
      REG_TIMEOUT:      timeout_reg  = data[6:0];
      REG_COOLDOWN:     cooldown_reg = data[7:0];
      REG_FAR:          far_reg      = data[CM_W-1:0];
      REG_TRIGGER:      trigger_reg  = data[TRIG_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic report(input string what, input ranger_beat_t want, input ranger_beat_t got);
    mismatches++;
    if (mismatches <= REPORT_MAX)
      $display("%0t %s: want trig %b valid %b cm %0d, got trig %b valid %b cm %0d",
               $realtime, what, want.trig, want.valid, want.cm, got.trig, got.valid, got.cm);
  endtask

  always @(posedge clk) begin
    ranger_beat_t want;
    ranger_beat_t got;
    out_stall <= ($urandom_range(99) < stall_pct);
    if (!rst && out_valid && !out_stall) begin
      got = '{trigger_level, result_valid, distance_cm};
      if (ranger_outputs_due.size() == 0) begin
        report("unexpected beat", '0, got);
      end else begin
        want = ranger_outputs_due.pop_front();
        if (got.trig !== want.trig || got.valid !== want.valid || got.cm !== want.cm)
          report("mismatch", want, got);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("ultrasonic_ranger_averaging_test: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic echo_now;
    int   echo_run;
    int   tick_pct;
    int   beats;
    plan_row_t row;
    echo_now = 1'b0;
    echo_run = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    reset_ranger();

    for (int r = 0; r < NUM_ROWS; r++) begin
      row = DIRECTED_PLAN[r];
      if (row.kind == ROW_REG) begin
        drain_results();
        write_reg(row.index, row.data);
      end else begin
        for (int k = 0; k < int'(row.reps); k++)
          send_beat(row.echo, row.tick, row.typed, row.want);
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_results();
      case (p)
        0: begin
          write_reg(REG_SAMPLE_COUNT, 11'd1);
          write_reg(REG_TIMEOUT, 11'd0);
          write_reg(REG_COOLDOWN, 11'd0);
          write_reg(REG_FAR, 11'd0);
          write_reg(REG_TRIGGER, 11'd1);
          tick_pct = 50;
          beats = 100;
        end
        1: begin
          write_reg(REG_SAMPLE_COUNT, 11'h7FF);
          write_reg(REG_FAR, 11'($urandom_range(2047)));
          tick_pct = 50;
          beats = 200;
        end
        2: begin
          write_reg(REG_SAMPLE_COUNT, 11'd2);
          write_reg(REG_TIMEOUT, 11'd1);
          write_reg(REG_COOLDOWN, 11'd1);
          write_reg(REG_FAR, 11'd2047);
          write_reg(REG_TRIGGER, 11'd63);
          tick_pct = 5;
          beats = 100;
        end
        3: begin
          write_reg(REG_SAMPLE_COUNT, 11'd1);
          write_reg(REG_TIMEOUT, 11'd127);
          write_reg(REG_COOLDOWN, 11'd255);
          write_reg(REG_TRIGGER, 11'd2);
          tick_pct = 100;
          beats = 300;
        end
        default: begin
          write_reg(REG_SAMPLE_COUNT, 11'($urandom_range(4, 1)));
          write_reg(REG_TIMEOUT, 11'($urandom_range(20, 1)));
          write_reg(REG_COOLDOWN, 11'($urandom_range(5)));
          write_reg(REG_FAR, 11'($urandom_range(2047)));
          write_reg(REG_TRIGGER, 11'($urandom_range(20)));
          tick_pct = $urandom_range(30, 5);
          beats = 90;
        end
      endcase
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 66; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 66; end
        default: begin idle_pct = 38; stall_pct = 38; end
      endcase
      for (int k = 0; k < beats; k++) begin
        // mostly clean echo pulses, with short glitches mixed in
        if (echo_run == 0) begin
          echo_now = ~echo_now;
          if ($urandom_range(9) == 0)
            echo_run = $urandom_range(2, 1);
          else if (echo_now)
            echo_run = ($urandom_range(9) == 0) ? $urandom_range(4000, 1) : $urandom_range(150, 1);
          else
            echo_run = $urandom_range(40, 1);
        end
        echo_run--;
        if ($urandom_range(149) == 0) drain_results();
        send_beat(echo_now, $urandom_range(99) < tick_pct, 1'b0, '0);
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && ranger_outputs_due.size() == 0) begin
      $display("ultrasonic_ranger_averaging_test: clean");
    end else begin
      $display("ultrasonic_ranger_averaging_test: errors");
    end
    $finish;
  end

endmodule
